@@ sv/wcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_pkg
// Types and constants shared by the wall color compensation pipeline.
// ----------------------------------------------------------------------------
package wcc_pkg;

   localparam int CH_W   = 8;    // one color channel
   localparam int PROD_W = 16;   // channel times wall byte
   localparam int NUM_W  = 26;   // 2*255*px*w + w*px, below 2^26
   localparam int DEN_W  = 17;   // 2*w*px
   localparam int QBITS  = 8;    // quotient never exceeds 255
   localparam int CSR_IDX_W = 3;

   typedef logic [CH_W-1:0]   chan_type;
   typedef chan_type [2:0]    rgb_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [DEN_W-1:0]  den_type;

   localparam logic [CSR_IDX_W-1:0] CSR_COMP_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_VALID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_RED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_GREEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_BLUE   = 3'd4;

   localparam chan_type WALL_RESET = 8'hFF;

endpackage

@@ sv/wall_color_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_color_compensation
// Divides each channel by the wall reflectance and rescales the pixel so
// that its dominant channel lands on 255, rounding to nearest.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle unless rsp_tready stalls the output; the
// 12-stage pipeline is four stages of products and setup followed by an
// eight-stage restoring divider that resolves one quotient bit per stage
// for all three channels.
// Reset: all stage valid bits clear, compensation off, wall bytes 255.
// ----------------------------------------------------------------------------
module wall_color_compensation
   import wcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // in_red, in_green, in_blue
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // out_red, out_green, out_blue
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   // configuration
   logic     comp_enable_ff;
   logic     wall_valid_ff;
   rgb_type  wall_ff;

   // stage 1: floored wall bytes and cross products
   logic     v1_ff;
   rgb_type  px1_ff, w1_ff;
   logic     pass1_ff, zero1_ff;
   prod_type p10_ff, p01_ff, p20_ff, p02_ff, p21_ff, p12_ff;
   rgb_type  w1_in;
   logic     rdy1;

   // stage 2: dominant channel picked
   logic     v2_ff;
   rgb_type  px2_ff, w2_ff;
   chan_type pxm2_ff, wm2_ff;
   logic     pass2_ff, zero2_ff;
   logic     m1_sel, m2_sel;
   chan_type pxm2_in, wm2_in;
   logic     rdy2;

   // stage 3: numerator and denominator products
   logic     v3_ff;
   rgb_type  px3_ff;
   logic     pass3_ff, zero3_ff;
   prod_type np3_ff [3];
   prod_type dp3_ff [3];
   logic     rdy3;

   // stage 4: rounded dividend and divisor
   logic     v4_ff;
   rgb_type  px4_ff;
   logic     pass4_ff, zero4_ff;
   num_type  n4_ff [3];
   den_type  d4_ff [3];
   logic     rdy4;

   // divider stages, stage j resolves quotient bit QBITS-1-j
   logic     dv_ff    [QBITS];
   num_type  rem_ff   [QBITS][3];
   den_type  den_ff   [QBITS][3];
   rgb_type  q_ff     [QBITS];
   rgb_type  dpx_ff   [QBITS];
   logic     dpass_ff [QBITS];
   logic     dzero_ff [QBITS];
   num_type  rem_in   [QBITS][3];
   rgb_type  q_in     [QBITS];
   logic     drdy     [QBITS];

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         comp_enable_ff <= 1'b0;
         wall_valid_ff  <= 1'b0;
         wall_ff        <= {WALL_RESET, WALL_RESET, WALL_RESET};
      end else if (csr_we) begin
         case (csr_index)
            CSR_COMP_ENABLE: comp_enable_ff <= csr_wdata[0];
            CSR_WALL_VALID:  wall_valid_ff  <= csr_wdata[0];
            CSR_WALL_RED:    wall_ff[0]     <= csr_wdata;
            CSR_WALL_GREEN:  wall_ff[1]     <= csr_wdata;
            CSR_WALL_BLUE:   wall_ff[2]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // flow control: a stage loads when it is empty or its content moves on
   // ------------------------------------------------------------------
   always_comb begin
      drdy[QBITS-1] = !dv_ff[QBITS-1] || rsp_tready;
      for (int j = QBITS - 2; j >= 0; j--) begin
         drdy[j] = !dv_ff[j] || drdy[j+1];
      end
   end

   assign rdy4       = !v4_ff || drdy[0];
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   // ------------------------------------------------------------------
   // stage 1
   // ------------------------------------------------------------------
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         w1_in[c] = (wall_ff[c] == '0) ? 8'd1 : wall_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         px1_ff   <= req_tdata;
         w1_ff    <= w1_in;
         pass1_ff <= !(comp_enable_ff && wall_valid_ff);
         zero1_ff <= (req_tdata == '0);
         p10_ff   <= PROD_W'(req_tdata[15:8])  * PROD_W'(w1_in[0]);
         p01_ff   <= PROD_W'(req_tdata[7:0])   * PROD_W'(w1_in[1]);
         p20_ff   <= PROD_W'(req_tdata[23:16]) * PROD_W'(w1_in[0]);
         p02_ff   <= PROD_W'(req_tdata[7:0])   * PROD_W'(w1_in[2]);
         p21_ff   <= PROD_W'(req_tdata[23:16]) * PROD_W'(w1_in[1]);
         p12_ff   <= PROD_W'(req_tdata[15:8])  * PROD_W'(w1_in[2]);
      end
   end

   // ------------------------------------------------------------------
   // stage 2: the first strictly larger ratio wins, so ties keep red first
   // ------------------------------------------------------------------
   always_comb begin
      m1_sel = (p10_ff > p01_ff);
      m2_sel = m1_sel ? (p21_ff > p12_ff) : (p20_ff > p02_ff);
      if (m2_sel) begin
         pxm2_in = px1_ff[2];
         wm2_in  = w1_ff[2];
      end else if (m1_sel) begin
         pxm2_in = px1_ff[1];
         wm2_in  = w1_ff[1];
      end else begin
         pxm2_in = px1_ff[0];
         wm2_in  = w1_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         px2_ff   <= px1_ff;
         w2_ff    <= w1_ff;
         pxm2_ff  <= pxm2_in;
         wm2_ff   <= wm2_in;
         pass2_ff <= pass1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: px_c * w_m and w_c * px_m
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         px3_ff   <= px2_ff;
         pass3_ff <= pass2_ff;
         zero3_ff <= zero2_ff;
         for (int c = 0; c < 3; c++) begin
            np3_ff[c] <= PROD_W'(px2_ff[c]) * PROD_W'(wm2_ff);
            dp3_ff[c] <= PROD_W'(w2_ff[c]) * PROD_W'(pxm2_ff);
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 4: dividend 510*np + dp, divisor 2*dp (round half up)
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         px4_ff   <= px3_ff;
         pass4_ff <= pass3_ff;
         zero4_ff <= zero3_ff;
         for (int c = 0; c < 3; c++) begin
            n4_ff[c] <= (NUM_W'(np3_ff[c]) << 9) - (NUM_W'(np3_ff[c]) << 1)
                        + NUM_W'(dp3_ff[c]);
            d4_ff[c] <= {dp3_ff[c], 1'b0};
         end
      end
   end

   // ------------------------------------------------------------------
   // divider stages
   // ------------------------------------------------------------------
   always_comb begin
      num_type  rem_cur;
      num_type  trial;
      den_type  den_cur;
      chan_type q_cur;
      for (int j = 0; j < QBITS; j++) begin
         for (int c = 0; c < 3; c++) begin
            rem_cur = (j == 0) ? n4_ff[c] : rem_ff[(j == 0) ? 0 : j-1][c];
            den_cur = (j == 0) ? d4_ff[c] : den_ff[(j == 0) ? 0 : j-1][c];
            q_cur   = (j == 0) ? '0 : q_ff[(j == 0) ? 0 : j-1][c];
            trial   = NUM_W'(den_cur) << (QBITS - 1 - j);
            if (rem_cur >= trial) begin
               rem_in[j][c] = rem_cur - trial;
               q_cur[QBITS-1-j] = 1'b1;
            end else begin
               rem_in[j][c] = rem_cur;
            end
            q_in[j][c] = q_cur;
         end
      end
      // the last stage also picks bypass or black
      if (dpass_ff[QBITS-2]) begin
         q_in[QBITS-1] = dpx_ff[QBITS-2];
      end else if (dzero_ff[QBITS-2]) begin
         q_in[QBITS-1] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QBITS; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else begin
         if (drdy[0]) begin
            dv_ff[0] <= v4_ff;
         end
         for (int j = 1; j < QBITS; j++) begin
            if (drdy[j]) begin
               dv_ff[j] <= dv_ff[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (drdy[0]) begin
         dpx_ff[0]   <= px4_ff;
         dpass_ff[0] <= pass4_ff;
         dzero_ff[0] <= zero4_ff;
         q_ff[0]     <= q_in[0];
         for (int c = 0; c < 3; c++) begin
            rem_ff[0][c] <= rem_in[0][c];
            den_ff[0][c] <= d4_ff[c];
         end
      end
      for (int j = 1; j < QBITS; j++) begin
         if (drdy[j]) begin
            dpx_ff[j]   <= dpx_ff[j-1];
            dpass_ff[j] <= dpass_ff[j-1];
            dzero_ff[j] <= dzero_ff[j-1];
            q_ff[j]     <= q_in[j];
            for (int c = 0; c < 3; c++) begin
               rem_ff[j][c] <= rem_in[j][c];
               den_ff[j][c] <= den_ff[j-1][c];
            end
         end
      end
   end

   assign rsp_tvalid = dv_ff[QBITS-1];
   assign rsp_tdata  = q_ff[QBITS-1];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------

   // The dominant channel bounds every quotient below 256.
   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[0] && !dpass_ff[0] && !dzero_ff[0]) |->
         (rem_ff[0][0] < (NUM_W'(den_ff[0][0]) << (QBITS - 1))) &&
         (rem_ff[0][1] < (NUM_W'(den_ff[0][1]) << (QBITS - 1))) &&
         (rem_ff[0][2] < (NUM_W'(den_ff[0][2]) << (QBITS - 1))))
      else $error("quotient exceeds eight bits");

   // After the last bit the remainder is smaller than the divisor.
   a_rem_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !dpass_ff[QBITS-1] && !dzero_ff[QBITS-1]) |->
         (rem_ff[QBITS-1][0] < NUM_W'(den_ff[QBITS-1][0])) &&
         (rem_ff[QBITS-1][1] < NUM_W'(den_ff[QBITS-1][1])) &&
         (rem_ff[QBITS-1][2] < NUM_W'(den_ff[QBITS-1][2])))
      else $error("divider remainder not reduced");

   // A compensated nonzero pixel always has one channel at full scale.
   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !dpass_ff[QBITS-1] && !dzero_ff[QBITS-1]) |->
         (rsp_tdata[7:0] == 8'hFF || rsp_tdata[15:8] == 8'hFF ||
          rsp_tdata[23:16] == 8'hFF))
      else $error("dominant channel not normalized");

   // An empty first stage always takes a request.
   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready)
      else $error("request refused with empty input stage");

endmodule

@@ verif/wcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_checker
// Watches the request, response and register ports of the wall color
// compensation block. It keeps its own copy of the register settings,
// predicts the compensated pixel for every accepted request and compares
// each accepted response, channel by channel, with the oldest prediction.
// ----------------------------------------------------------------------------
module wcc_checker
   import wcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [23:0]          req_tdata,   // in_red, in_green, in_blue
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [23:0]          rsp_tdata,   // out_red, out_green, out_blue
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   output int                   mismatches,
   output int                   pending
);

   logic     comp_on;
   logic     wall_set;
   chan_type wall_byte [3];
   rgb_type  expected_pixels [$];
   string    chan_name [3] = '{"red", "green", "blue"};

   // Exact integer form of the compensation: each channel is scaled by
   // 255 * w_dom / (w_c * px_dom), rounded half up and clamped.
   function automatic rgb_type compensate_pixel(input rgb_type px);
      longint unsigned w [3];
      longint unsigned p [3];
      longint unsigned num;
      longint unsigned den;
      longint unsigned q;
      int              dom;
      rgb_type         res;
      if (!comp_on || !wall_set) return px;
      if (px == '0) return '0;
      for (int c = 0; c < 3; c++) begin
         p[c] = 64'(px[c]);
         w[c] = (wall_byte[c] == 0) ? 64'd1 : 64'(wall_byte[c]);
      end
      dom = 0;
      for (int c = 1; c < 3; c++) begin
         if (p[c] * w[dom] > p[dom] * w[c]) dom = c;
      end
      for (int c = 0; c < 3; c++) begin
         num = 255 * p[c] * w[dom];
         den = w[c] * p[dom];
         q   = (2 * num + den) / (2 * den);
         res[c] = (q > 255) ? 8'd255 : q[7:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      if (reset) begin
         comp_on  = 1'b0;
         wall_set = 1'b0;
         for (int c = 0; c < 3; c++) wall_byte[c] = WALL_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               $display("%0t: response %h with no request outstanding", $time, got);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               for (int c = 0; c < 3; c++) begin
                  if (got[c] !== want[c]) begin
                     $display("%0t: %s expected %0d, got %0d",
                              $time, chan_name[c], want[c], got[c]);
                     mismatches++;
                  end
               end
            end
         end
         // A request is predicted with the settings in force before any
         // register write at the same edge.
         if (req_tvalid && req_tready)
            expected_pixels.push_back(compensate_pixel(req_tdata));
         if (csr_we) begin
            case (csr_index)
               CSR_COMP_ENABLE: comp_on      = csr_wdata[0];
               CSR_WALL_VALID:  wall_set     = csr_wdata[0];
               CSR_WALL_RED:    wall_byte[0] = csr_wdata;
               CSR_WALL_GREEN:  wall_byte[1] = csr_wdata;
               CSR_WALL_BLUE:   wall_byte[2] = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = expected_pixels.size();
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixels and wall settings into the wall color compensation block.
// A directed pass covers pass-through, black pixels, primaries, ties and
// zero wall bytes; random phases with new wall settings follow, with random
// gaps and back-pressure. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_top
   import wcc_pkg::*;
();

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata  = '0;   // in_red, in_green, in_blue
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;         // out_red, out_green, out_blue
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_COMP_ENABLE;
   logic [7:0]           csr_wdata  = '0;
   logic                 calm       = 1'b0;
   int                   mismatches;
   int                   pending;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   wall_color_compensation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wcc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // The receiver stalls now and then, except during the calm phase.
   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
   end

   initial begin
      #2400000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic rgb_type pix(input int r, input int g, input int b);
      return {b[7:0], g[7:0], r[7:0]};
   endfunction

   function automatic chan_type pick_channel();
      case ($urandom_range(0, 4))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return chan_type'($urandom_range(1, 3));
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic rgb_type random_pixel();
      int      mode;
      chan_type v;
      mode = $urandom_range(0, 9);
      v    = chan_type'($urandom_range(0, 255));
      if (mode < 5) return rgb_type'($urandom());
      if (mode < 8) return {pick_channel(), pick_channel(), pick_channel()};
      // Two channels equal, so the dominant channel is a tie on a white wall.
      if (mode == 8) return pix(v, v, $urandom_range(0, v));
      return pix($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
   endfunction

   // Sample tready mid-cycle, where nothing is changing, and hold the
   // request until the edge that takes it.
   task automatic send_pixel(input rgb_type px);
      logic taken;
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic program_wall(input logic en, input logic valid,
                               input chan_type r, input chan_type g, input chan_type b);
      logic [CSR_IDX_W-1:0] idx [5];
      logic [7:0]           val [5];
      idx = '{CSR_COMP_ENABLE, CSR_WALL_VALID, CSR_WALL_RED, CSR_WALL_GREEN, CSR_WALL_BLUE};
      val = '{{7'd0, en}, {7'd0, valid}, r, g, b};
      wait_drained();
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic chan_type wall_pick();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd255;
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic en;
      logic valid;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at reset: compensation off, so pixels pass through.
      send_pixel(pix(0, 0, 0));
      send_pixel(pix(255, 255, 255));
      send_pixel(pix(18, 200, 77));

      program_wall(1'b1, 1'b1, 8'd255, 8'd255, 8'd255);
      send_pixel(pix(0, 0, 0));
      send_pixel(pix(255, 0, 0));
      send_pixel(pix(0, 255, 0));
      send_pixel(pix(0, 0, 1));
      send_pixel(pix(1, 2, 3));
      send_pixel(pix(128, 128, 64));
      send_pixel(pix(1, 1, 1));
      send_pixel(pix(128, 64, 1));

      // A zero wall byte floors to the same reflectance as a byte of one.
      program_wall(1'b1, 1'b1, 8'd0, 8'd1, 8'd255);
      send_pixel(pix(1, 1, 1));
      send_pixel(pix(255, 255, 255));
      send_pixel(pix(5, 0, 0));
      send_pixel(pix(0, 0, 200));
      send_pixel(pix(0, 0, 0));

      program_wall(1'b1, 1'b0, 8'd40, 8'd170, 8'd90);
      send_pixel(pix(33, 66, 99));
      program_wall(1'b0, 1'b1, 8'd40, 8'd170, 8'd90);
      send_pixel(pix(33, 66, 99));
      program_wall(1'b1, 1'b1, 8'd40, 8'd170, 8'd90);
      send_pixel(pix(33, 66, 99));
      send_pixel(pix(254, 127, 3));

      for (int ph = 0; ph < 6; ph++) begin
         en    = (ph == 1) ? 1'b0 : ($urandom_range(9) != 0);
         valid = ($urandom_range(9) != 0);
         program_wall(en, valid, wall_pick(), wall_pick(), wall_pick());
         calm = (ph == 3);
         for (int i = 0; i < 125; i++) send_pixel(random_pixel());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/wcc_pkg.sv
sv/wall_color_compensation.sv
verif/wcc_checker.sv
verif/tb_top.sv
